// ===== src/gmcp_pkg.sv =====
// gmcp_pkg: shared types and constants of the grid min-cost-path block
// no dependencies; imported by gmcp_pos, gmcp_step, the top level and the bench
`default_nettype none

package gmcp_pkg;

	// configuration register width and index codes
	localparam int REG_BITS     = 9;
	localparam int REG_IDX_BITS = 1;
	localparam logic [REG_IDX_BITS-1:0] REG_ROWS = 1'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_COLS = 1'd1;

	// default sizes
	localparam int DEF_MAX_ROWS  = 256;
	localparam int DEF_MAX_COLS  = 256;
	localparam int DEF_COST_BITS = 16;

	// where a cell sits in the grid
	typedef struct packed {
		logic row0;   // cell lies in the top row
		logic col0;   // cell lies in the left column
		logic last;   // bottom-right cell, closes the grid
	} cell_flags_t;

endpackage

`default_nettype wire

// ===== src/gmcp_ram.sv =====
// gmcp_ram: generic single-write, single-read RAM with registered read data
// no dependencies; holds the line buffer of best costs
`default_nettype none

module gmcp_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 256
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/gmcp_pos.sv =====
// gmcp_pos: grid size registers and row/column position of the next cell
// depends on gmcp_pkg
`default_nettype none

module gmcp_pos
	import gmcp_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [REG_IDX_BITS-1:0] cfg_index,
	input  wire logic [REG_BITS-1:0]     cfg_data,
	input  wire logic                    accept,
	output logic      [COL_W-1:0]        col,
	output cell_flags_t                  flags
);

	localparam int RW = (ROW_W > REG_BITS) ? ROW_W : REG_BITS;
	localparam int CW = (COL_W > REG_BITS) ? COL_W : REG_BITS;
	localparam logic [RW-1:0] ROW_LIM = RW'(MAX_ROWS - 1);
	localparam logic [CW-1:0] COL_LIM = CW'(MAX_COLS - 1);

	logic [RW-1:0]    rows_m1_q, rows_m1_d;
	logic [CW-1:0]    cols_m1_q, cols_m1_d;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             last_row, last_col;

	// clamp written sizes: zero acts as one, above max acts as max
	always_comb begin
		if (cfg_data == '0) begin
			rows_m1_d = '0;
		end else if (RW'(cfg_data) - RW'(1) > ROW_LIM) begin
			rows_m1_d = ROW_LIM;
		end else begin
			rows_m1_d = RW'(cfg_data) - RW'(1);
		end
	end

	always_comb begin
		if (cfg_data == '0) begin
			cols_m1_d = '0;
		end else if (CW'(cfg_data) - CW'(1) > COL_LIM) begin
			cols_m1_d = COL_LIM;
		end else begin
			cols_m1_d = CW'(cfg_data) - CW'(1);
		end
	end

	assign last_row = (RW'(row_q) == rows_m1_q);
	assign last_col = (CW'(col_q) == cols_m1_q);

	// size registers; any write restarts the grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m1_q <= '0;
			cols_m1_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_m1_q <= rows_m1_d;
				REG_COLS: cols_m1_q <= cols_m1_d;
				default:  rows_m1_q <= rows_m1_q;
			endcase
		end
	end

	// position of the next cell, row-major walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_we) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col && last_row) begin
				row_q <= '0;
				col_q <= '0;
			end else if (last_col) begin
				row_q <= row_q + 1'b1;
				col_q <= '0;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign col        = col_q;
	assign flags.row0 = (row_q == '0);
	assign flags.col0 = (col_q == '0);
	assign flags.last = last_row && last_col;

`ifndef SYNTHESIS
	// column never passes the configured width
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(col_q) <= cols_m1_q)
		else $error("column position beyond configured width");

	// row never passes the configured height
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		RW'(row_q) <= rows_m1_q)
		else $error("row position beyond configured height");

	// the closing cell returns the walk to the top-left corner
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && flags.last |=> row_q == '0 && col_q == '0)
		else $error("position did not restart after last cell");

	// end of a row steps down one row and back to column zero
	a_next_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_we && last_col && !last_row
		|=> col_q == '0 && row_q == $past(row_q) + 1'b1)
		else $error("bad step to next row");
`endif

endmodule

`default_nettype wire

// ===== src/gmcp_step.sv =====
// gmcp_step: cell stage register, min-of-neighbors plus cost, left/diagonal
// registers and result register; depends on gmcp_pkg, drives the line buffer
`default_nettype none

module gmcp_step
	import gmcp_pkg::*;
#(
	parameter int COST_BITS = DEF_COST_BITS,
	parameter int PATH_BITS = 25,
	parameter int ADDR_W    = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [COST_BITS-1:0] cost,
	input  wire logic [ADDR_W-1:0]    col,
	input  wire cell_flags_t          flags,
	output logic                      stage_free,
	// line buffer ports
	input  wire logic [PATH_BITS-1:0] rdata,
	output logic                      we,
	output logic      [ADDR_W-1:0]    waddr,
	output logic      [PATH_BITS-1:0] wdata,
	// result word
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output logic      [PATH_BITS-1:0] res_cost
);

	logic                 valid_s1;
	logic [COST_BITS-1:0] cost_s1;
	logic [ADDR_W-1:0]    col_s1;
	cell_flags_t          flags_s1;
	logic                 byp_s1;
	logic [PATH_BITS-1:0] bypd_s1;

	logic [PATH_BITS-1:0] left_q, diag_q;
	logic                 out_valid_q;
	logic [PATH_BITS-1:0] out_cost_q;

	logic                 adv;
	logic [PATH_BITS-1:0] above, prev, best;
	logic [PATH_BITS:0]   sum;

	// stage moves on unless a closing cell meets a blocked result register
	assign adv        = valid_s1 && (!flags_s1.last || !out_valid_q || res_ready);
	assign stage_free = !valid_s1 || adv;

	// cell stage; catches a line buffer write to the address being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cost_s1  <= cost;
			col_s1   <= col;
			flags_s1 <= flags;
			byp_s1   <= we && (waddr == col);
			bypd_s1  <= wdata;
		end
	end

	// best of the three neighbors
	always_comb begin
		above = byp_s1 ? bypd_s1 : rdata;
		if (flags_s1.row0 && flags_s1.col0) begin
			prev = '0;
		end else if (flags_s1.row0) begin
			prev = left_q;
		end else if (flags_s1.col0) begin
			prev = above;
		end else begin
			prev = (above < left_q) ? above : left_q;
			if (diag_q < prev) begin
				prev = diag_q;
			end
		end
	end

	// add cell cost, saturating
	assign sum  = {1'b0, prev} + (PATH_BITS + 1)'(cost_s1);
	assign best = sum[PATH_BITS] ? '1 : sum[PATH_BITS-1:0];

	assign we    = adv;
	assign waddr = col_s1;
	assign wdata = best;

	// left and diagonal neighbors for the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			diag_q <= '0;
		end else if (adv) begin
			left_q <= best;
			diag_q <= above;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && flags_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && flags_s1.last) begin
			out_cost_q <= best;
		end
	end

	assign res_valid = out_valid_q;
	assign res_cost  = out_cost_q;

`ifndef SYNTHESIS
	// a closing cell always produces a result word next cycle
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && flags_s1.last |=> out_valid_q)
		else $error("closing cell did not raise a result");

	// a result word only follows a closing cell or an unread result
	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && flags_s1.last))
		else $error("result raised without a closing cell");

	// a stalled cell keeps its line buffer write back
	a_stall_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> !we)
		else $error("line buffer written by a stalled cell");
`endif

endmodule

`default_nettype wire

// ===== src/grid_min_cost_path_top.sv =====
// grid_min_cost_path_top: top level of the grid min-cost-path block
// depends on gmcp_pkg, gmcp_pos, gmcp_step, gmcp_ram
`default_nettype none

// Takes grid costs one word per cycle in row-major order and, after the
// bottom-right cell, emits one word with the least cost of a path from the
// top-left cell moving right, down or diagonally down-right (both end cells
// counted). A cell is accepted every cycle: it is registered with its line
// buffer read, and the next cycle one compare-and-add stage forms its best
// cost; the last cell's cost goes into the result register that drives
// m_tdata. Rate is bound by the line buffer (one read, one write per cycle)
// and the left/diagonal feedback through that one stage. Only a closing cell
// stalls, and only while an earlier result is unread; input waits behind it.
// Writing rows_in_use or cols_in_use restarts the grid; a size of zero acts
// as one, a size above the maximum acts as the maximum.

module grid_min_cost_path_top
	import gmcp_pkg::*;
#(
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int COST_BITS = DEF_COST_BITS,
	localparam int PATH_BITS = COST_BITS + $clog2(MAX_ROWS + MAX_COLS),
	localparam int IN_TW     = ((COST_BITS + 7) / 8) * 8,
	localparam int OUT_TW    = ((PATH_BITS + 7) / 8) * 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration write
	input  wire logic                    cfg_we,
	input  wire logic [REG_IDX_BITS-1:0] cfg_index,
	input  wire logic [REG_BITS-1:0]     cfg_data,
	// cell cost stream
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [IN_TW-1:0]        s_tdata,   // [COST_BITS-1:0] cell_cost
	// path cost stream
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic      [OUT_TW-1:0]       m_tdata    // [PATH_BITS-1:0] path_cost
);

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic                 accept;
	logic                 stage_free;
	logic [COL_W-1:0]     col;
	cell_flags_t          flags;
	logic                 ram_we;
	logic [COL_W-1:0]     ram_waddr;
	logic [PATH_BITS-1:0] ram_wdata, ram_rdata;
	logic [PATH_BITS-1:0] path_cost;

	assign s_tready = stage_free;
	assign accept   = s_tvalid && stage_free;

	// position sequencer and size registers
	gmcp_pos #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.col       (col),
		.flags     (flags)
	);

	// line buffer of best costs of the previous row
	gmcp_ram #(
		.WIDTH (PATH_BITS),
		.DEPTH (MAX_COLS)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (col),
		.rdata (ram_rdata)
	);

	// cost stage and result register
	gmcp_step #(
		.COST_BITS (COST_BITS),
		.PATH_BITS (PATH_BITS),
		.ADDR_W    (COL_W)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cost       (s_tdata[COST_BITS-1:0]),
		.col        (col),
		.flags      (flags),
		.stage_free (stage_free),
		.rdata      (ram_rdata),
		.we         (ram_we),
		.waddr      (ram_waddr),
		.wdata      (ram_wdata),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_cost   (path_cost)
	);

	assign m_tdata = OUT_TW'(path_cost);

endmodule

`default_nettype wire

// ===== bench/grid_min_cost_path_top_tb.sv =====
// grid_min_cost_path_top_tb: self-checking bench for the grid min-cost-path block
// streams directed and random grids, predicts each path cost and checks every result word
// depends on gmcp_pkg and grid_min_cost_path_top

module grid_min_cost_path_top_tb;
	import gmcp_pkg::*;

	localparam int MAX_DIM     = 256;
	localparam int COST_W      = 16;
	localparam int PATH_W      = 25;
	localparam int IN_TW       = 16;
	localparam int OUT_TW      = 32;
	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_CELLS  = 40;    // cells per idling phase
	localparam int RAND_AREA   = 64;    // largest random grid
	localparam int SETTLE      = 8;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [REG_IDX_BITS-1:0] cfg_index = '0;
	logic [REG_BITS-1:0]     cfg_data  = '0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [IN_TW-1:0]        s_tdata   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OUT_TW-1:0]       m_tdata;

	// stimulus and idling control
	logic [COST_W-1:0] cell_q [$];
	int send_idle    = 35;
	int recv_idle    = 80;
	int holds_asked  = 0;
	int holds_taken  = 0;
	int hold_left    = 0;
	int cells_sent   = 0;
	int cycle_count  = 0;
	int mismatch_count = 0;

	// predictor state: configuration, line buffer and neighbor registers
	logic [REG_BITS-1:0] rows_reg  = 9'd1;
	logic [REG_BITS-1:0] cols_reg  = 9'd1;
	logic [PATH_W-1:0]   line_best [MAX_DIM];
	logic [PATH_W-1:0]   left_best = '0;
	logic [PATH_W-1:0]   diag_best = '0;
	int                  grid_row  = 0;
	int                  grid_col  = 0;
	logic [PATH_W-1:0]   expected_path_costs [$];
	logic [PATH_W-1:0]   next_path_cost;

	grid_min_cost_path_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [15:0] cell_cost
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)     // [24:0] path_cost
	);

	always #2 clk = ~clk;

	// size register as the block sees it: zero acts as one, oversize as the maximum
	function automatic int eff_dim(input logic [REG_BITS-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	function automatic void restart_grid();
		left_best = '0;
		diag_best = '0;
		grid_row  = 0;
		grid_col  = 0;
	endfunction

	// one cell of the forward recurrence; queues the total after the last cell
	function automatic void step_grid_cell(input logic [COST_W-1:0] cost);
		int                rows_eff;
		int                cols_eff;
		logic [PATH_W-1:0] prev;
		logic [PATH_W-1:0] above;
		logic [PATH_W-1:0] best;
		logic [PATH_W:0]   sum;
		rows_eff = eff_dim(rows_reg);
		cols_eff = eff_dim(cols_reg);
		if (grid_row >= rows_eff || grid_col >= cols_eff)
			restart_grid();
		above = (grid_row == 0) ? '0 : line_best[grid_col];
		if (grid_row == 0 && grid_col == 0)
			prev = '0;
		else if (grid_row == 0)
			prev = left_best;
		else if (grid_col == 0)
			prev = above;
		else begin
			prev = left_best;
			if (above < prev)
				prev = above;
			if (diag_best < prev)
				prev = diag_best;
		end
		sum  = {1'b0, prev} + (PATH_W + 1)'(cost);
		best = sum[PATH_W] ? '1 : sum[PATH_W-1:0];
		diag_best = above;
		line_best[grid_col] = best;
		left_best = best;
		if (grid_row + 1 >= rows_eff && grid_col + 1 >= cols_eff) begin
			expected_path_costs.push_back(best);
			restart_grid();
		end else if (grid_col + 1 >= cols_eff) begin
			grid_col  = 0;
			grid_row  = grid_row + 1;
			left_best = '0;
			diag_best = '0;
		end else begin
			grid_col = grid_col + 1;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// cost mix: small values, the two extremes, and full-range values
	function automatic logic [COST_W-1:0] rand_cost();
		case ($urandom_range(3))
			0: return COST_W'($urandom_range(15));
			1: return $urandom_range(1) ? '1 : '0;
			default: return COST_W'($urandom_range(65535));
		endcase
	endfunction

	// mostly small sizes, now and then zero, the maximum or an oversized value
	function automatic int rand_dim();
		int pick;
		pick = $urandom_range(99);
		if (pick < 4)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 4);
		if (pick < 98)
			return $urandom_range(5, 16);
		return $urandom_range(1) ? MAX_DIM : $urandom_range(MAX_DIM + 1, 511);
	endfunction

	task automatic push_cells(input int n);
		repeat (n)
			cell_q.push_back(rand_cost());
		cells_sent += n;
	endtask

	// register write; the block is idle whenever this is called
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[REG_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROWS)
			rows_reg = value[REG_BITS-1:0];
		else
			cols_reg = value[REG_BITS-1:0];
		restart_grid();
	endtask

	// sender pause until all cells are taken and all results are back
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (cell_q.size() != 0 || s_tvalid || expected_path_costs.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// new size, a few whole grids, sometimes a grid cut short
	task automatic random_block();
		int r;
		int c;
		int cells;
		int grids;
		r = rand_dim();
		c = rand_dim();
		// keep random grids small so the run stays near its item count
		if (eff_dim(REG_BITS'(r)) * eff_dim(REG_BITS'(c)) > RAND_AREA)
			c = $urandom_range(2);
		if (eff_dim(REG_BITS'(r)) * eff_dim(REG_BITS'(c)) > RAND_AREA)
			r = $urandom_range(2);
		if ($urandom_range(1)) begin
			write_reg(REG_ROWS, r);
			write_reg(REG_COLS, c);
		end else begin
			write_reg(REG_COLS, c);
			write_reg(REG_ROWS, r);
		end
		cells = eff_dim(rows_reg) * eff_dim(cols_reg);
		grids = (cells > 16) ? 1 : $urandom_range(1, 5);
		@(negedge clk);
		repeat (grids) push_cells(cells);
		if (cells > 1 && $urandom_range(5) == 0)
			push_cells($urandom_range(1, cells - 1));
		wait_idle();
	endtask

	// cell driver: holds a word until taken, random gaps between words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (cell_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				s_tvalid <= 1'b1;
				s_tdata  <= cell_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls plus requested long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
		end else if (holds_taken != holds_asked) begin
			holds_taken <= holds_taken + 1;
			hold_left   <= HOLD_CYCLES;
			m_tready    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor: predict on each accepted cell, check each accepted result word
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			step_grid_cell(s_tdata[COST_W-1:0]);
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_path_costs.size() == 0) begin
				report_mismatch($sformatf("path_cost %0d with none pending", m_tdata));
			end else begin
				next_path_cost = expected_path_costs.pop_front();
				if (m_tdata !== {{(OUT_TW-PATH_W){1'b0}}, next_path_cost})
					report_mismatch($sformatf("path_cost got %0d want %0d",
						m_tdata, next_path_cost));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-cell grids at the reset size
		cell_q.push_back(16'h0000);
		cell_q.push_back(16'hffff);
		cell_q.push_back(16'h5555);
		cell_q.push_back(16'haaaa);
		wait_idle();

		// long receiver hold-off while one-cell grids keep coming
		holds_asked++;
		push_cells(16);
		wait_idle();

		// zero rows acts as one: a single row
		write_reg(REG_ROWS, 0);
		write_reg(REG_COLS, 3);
		@(negedge clk);
		cell_q.push_back(16'd1);
		cell_q.push_back(16'd2);
		cell_q.push_back(16'd3);
		wait_idle();

		// 2x2: all maximum, then a grid where the diagonal wins
		write_reg(REG_ROWS, 2);
		write_reg(REG_COLS, 2);
		@(negedge clk);
		repeat (4) cell_q.push_back(16'hffff);
		cell_q.push_back(16'd5);
		cell_q.push_back(16'd9);
		cell_q.push_back(16'd9);
		cell_q.push_back(16'd1);
		wait_idle();

		// zero columns acts as one: a single column
		write_reg(REG_ROWS, 3);
		write_reg(REG_COLS, 0);
		@(negedge clk);
		cell_q.push_back(16'd7);
		cell_q.push_back(16'd0);
		cell_q.push_back(16'hffff);
		wait_idle();

		// a register write part way through a grid starts it over
		write_reg(REG_ROWS, 3);
		write_reg(REG_COLS, 3);
		@(negedge clk);
		push_cells(4);
		wait_idle();
		write_reg(REG_COLS, 3);
		@(negedge clk);
		push_cells(9);
		wait_idle();

		// largest sizes, oversized settings among them
		write_reg(REG_ROWS, 300);
		write_reg(REG_COLS, 1);
		@(negedge clk);
		repeat (MAX_DIM) cell_q.push_back(16'hffff);
		wait_idle();
		write_reg(REG_ROWS, 1);
		write_reg(REG_COLS, 511);
		@(negedge clk);
		push_cells(MAX_DIM);
		wait_idle();

		// random grids under three idling patterns
		for (int ph = 0; ph < 3; ph++) begin
			@(negedge clk);
			send_idle  = (ph == 0) ? 35 : (ph == 1) ? 80 : 0;
			recv_idle  = (ph == 0) ? 80 : (ph == 1) ? 35 : 0;
			cells_sent = 0;
			while (cells_sent < RAND_CELLS)
				random_block();
		end
		wait_idle();

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
